// ===== sv/contiguous_partition_allocator_unit_defines.svh =====
// assertion macros for the partition allocator checker
// no dependencies; pulled in by the checker file only
`ifndef CONTIGUOUS_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define CPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cpa check failed");

// next-cycle implication
`define CPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cpa check failed");

`endif

// ===== sv/cpa_pkg.sv =====
// shared types, codes and defaults of the contiguous partition allocator
// no dependencies
package cpa_pkg;

	localparam int MAX_SEGMENTS_DFLT = 16;
	localparam int ADDRESS_BITS_DFLT = 16;

	localparam logic [15:0] RESET_MEMORY_TOP = 16'd1023;
	localparam logic [15:0] RESET_RSV_LENGTH = 16'd10;
	localparam logic [1:0]  RESET_FIT_MODE   = 2'd0;

	// configuration register indexes
	localparam logic [1:0] REG_FIT_MODE   = 2'd0;
	localparam logic [1:0] REG_MEMORY_TOP = 2'd1;
	localparam logic [1:0] REG_RSV_LENGTH = 2'd2;

	// fit modes, the unused code acts as first fit
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_NO_FIT    = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_SHIFT_UP,
		S_PLACE,
		S_SCAN_F,
		S_SHIFT_DN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  job_id;
		logic [15:0] size;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] addr;
	} res_t;

	typedef struct packed {
		logic [1:0]  fit_mode;
		logic [15:0] mem_top;
		logic [15:0] rsv_len;
		logic        clear;
	} cfg_t;

endpackage

// ===== sv/cpa_engine.sv =====
// segment table memory and the sequencer that scans, shifts and places entries
// depends on cpa_pkg
module cpa_engine #(
	parameter int MAX_SEG = cpa_pkg::MAX_SEGMENTS_DFLT,
	parameter int AW      = cpa_pkg::ADDRESS_BITS_DFLT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cpa_pkg::cfg_t cfg,
	input  logic          req_valid,
	output logic          req_ready,
	input  cpa_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output cpa_pkg::res_t res
);
	import cpa_pkg::*;

	localparam int CW = $clog2(MAX_SEG + 1);
	localparam int IW = $clog2(MAX_SEG);

	logic [7:0]    own_mem [MAX_SEG];
	logic [AW-1:0] sta_mem [MAX_SEG];
	logic [AW-1:0] len_mem [MAX_SEG];

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, ptr_q, pos_q;
	logic          dflt_q, found_q;
	logic [AW:0]   gap_q, prev_end_q;
	logic [AW-1:0] at_q, size_q;
	logic [7:0]    id_q;
	logic          kind_q;
	status_t       status_q;

	logic          rd_vld_s1, rd_zero_s1;
	logic [CW-1:0] rd_idx_s1;
	logic [7:0]    rd_own_s1;
	logic [AW-1:0] rd_sta_s1, rd_len_s1;

	logic [31:0]   top_w, rsv_w, size_w;
	logic [AW:0]   top1;
	logic [AW-1:0] rsv_m, size_m;
	logic [7:0]    rd_own;
	logic [AW-1:0] rd_sta, rd_len;
	logic [AW:0]   end_s1;
	logic          last_s1, match_s1;

	logic          ev_en, ev_ok, take;
	logic [AW:0]   ev_end, ev_lim, ev_gap;
	logic [CW-1:0] ev_pos;

	logic          rd_en, wr_en;
	logic [CW-1:0] rd_ptr, wr_ptr, ptr_dec;
	logic [7:0]    wr_own;
	logic [AW-1:0] wr_sta, wr_len;
	logic          accept, empty;

	assign top_w  = 32'(cfg.mem_top);
	assign rsv_w  = 32'(cfg.rsv_len);
	assign size_w = 32'(req.size);
	assign top1   = {1'b0, top_w[AW-1:0]} + (AW+1)'(1);
	assign rsv_m  = rsv_w[AW-1:0];
	assign size_m = size_w[AW-1:0];

	// entry 0 reads as the reserved region until it is first overwritten
	assign rd_own   = rd_zero_s1 ? 8'd0 : rd_own_s1;
	assign rd_sta   = rd_zero_s1 ? '0 : rd_sta_s1;
	assign rd_len   = rd_zero_s1 ? rsv_m : rd_len_s1;
	assign end_s1   = {1'b0, rd_sta} + {1'b0, rd_len};
	assign last_s1  = rd_idx_s1 == cnt_q - 1'b1;
	assign match_s1 = rd_own == id_q;
	assign ptr_dec  = ptr_q - 1'b1;
	assign accept   = req_valid && req_ready;
	assign empty    = cnt_q == '0;

	// gap evaluation: inner gaps during the scan, tail gap afterwards
	always_comb begin
		ev_end = prev_end_q;
		ev_lim = {1'b0, rd_sta};
		ev_pos = rd_idx_s1;
		ev_en  = 1'b0;
		if (state_q == S_SCAN) begin
			ev_en = rd_vld_s1 && (rd_idx_s1 != '0);
		end else if (state_q == S_TAIL) begin
			ev_lim = top1;
			ev_pos = cnt_q;
			ev_en  = 1'b1;
		end
		ev_gap = ev_lim - ev_end;
		ev_ok  = ev_en && (ev_end < ev_lim) && (ev_gap >= {1'b0, size_q});
		take   = ev_ok && (!found_q
			|| ((cfg.fit_mode == FIT_BEST) && (ev_gap < gap_q))
			|| ((cfg.fit_mode == FIT_WORST) && (ev_gap > gap_q)));
	end

	// memory ports and handshake outputs
	always_comb begin
		rd_en  = 1'b0;
		rd_ptr = ptr_q;
		wr_en  = 1'b0;
		wr_ptr = rd_idx_s1;
		wr_own = rd_own;
		wr_sta = rd_sta;
		wr_len = rd_len;
		case (state_q)
			S_SCAN, S_SCAN_F, S_SHIFT_DN: begin
				rd_en = ptr_q < cnt_q;
				if (state_q == S_SHIFT_DN) begin
					wr_en  = rd_vld_s1;
					wr_ptr = rd_idx_s1 - 1'b1;
				end
			end
			S_SHIFT_UP: begin
				rd_en  = ptr_q > pos_q;
				rd_ptr = ptr_dec;
				wr_en  = rd_vld_s1;
				wr_ptr = rd_idx_s1 + 1'b1;
			end
			S_PLACE: begin
				wr_en  = 1'b1;
				wr_ptr = pos_q;
				wr_own = id_q;
				wr_sta = at_q;
				wr_len = size_q;
			end
			default: ;
		endcase
		req_ready = state_q == S_IDLE;
		res_valid = state_q == S_DONE;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req.kind == KIND_FREE) begin
						state_d = empty ? S_DONE : S_SCAN_F;
					end else if (size_m == '0 || cnt_q >= CW'(MAX_SEG)) begin
						state_d = S_DONE;
					end else if (empty) begin
						state_d = (top1 >= {1'b0, size_m}) ? S_SHIFT_UP : S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN:     if (rd_vld_s1 && last_s1) state_d = S_TAIL;
			S_TAIL:     state_d = (found_q || take) ? S_SHIFT_UP : S_DONE;
			S_SHIFT_UP: if (!rd_en && !rd_vld_s1) state_d = S_PLACE;
			S_PLACE:    state_d = S_DONE;
			S_SCAN_F: begin
				if (rd_vld_s1) begin
					if (match_s1) state_d = S_SHIFT_DN;
					else if (last_s1) state_d = S_DONE;
				end
			end
			S_SHIFT_DN: if (!rd_en && !rd_vld_s1) state_d = S_DONE;
			S_DONE:     if (res_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_own_s1 <= own_mem[rd_ptr[IW-1:0]];
			rd_sta_s1 <= sta_mem[rd_ptr[IW-1:0]];
			rd_len_s1 <= len_mem[rd_ptr[IW-1:0]];
		end
		if (wr_en) begin
			own_mem[wr_ptr[IW-1:0]] <= wr_own;
			sta_mem[wr_ptr[IW-1:0]] <= wr_sta;
			len_mem[wr_ptr[IW-1:0]] <= wr_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= CW'(1);
			dflt_q     <= 1'b1;
			rd_vld_s1  <= 1'b0;
			rd_zero_s1 <= 1'b0;
			rd_idx_s1  <= '0;
			ptr_q      <= '0;
			found_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_vld_s1  <= rd_en;
			rd_zero_s1 <= rd_en && (rd_ptr == '0) && dflt_q;
			rd_idx_s1  <= rd_ptr;
			if (rd_en) begin
				ptr_q <= (state_q == S_SHIFT_UP) ? ptr_dec : ptr_q + 1'b1;
			end
			if (accept) begin
				ptr_q   <= '0;
				found_q <= (req.kind == KIND_ALLOC) && empty;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (state_q == S_TAIL) ptr_q <= cnt_q;
			if (wr_en && wr_ptr == '0) dflt_q <= 1'b0;
			if (state_q == S_PLACE) cnt_q <= cnt_q + 1'b1;
			if (state_q == S_SHIFT_DN && state_d == S_DONE) cnt_q <= cnt_q - 1'b1;
			if (cfg.clear) begin
				cnt_q  <= CW'(1);
				dflt_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.kind;
			id_q   <= req.job_id;
			size_q <= size_m;
			gap_q  <= '0;
			at_q   <= '0;
			pos_q  <= '0;
			if (req.kind == KIND_FREE) status_q <= STAT_NOT_FOUND;
			else if (size_m == '0) status_q <= STAT_NO_FIT;
			else if (cnt_q >= CW'(MAX_SEG)) status_q <= STAT_FULL;
			else if (empty && top1 >= {1'b0, size_m}) status_q <= STAT_DONE;
			else status_q <= STAT_NO_FIT;
		end
		if (take) begin
			gap_q <= ev_gap;
			at_q  <= ev_end[AW-1:0];
			pos_q <= ev_pos;
		end
		if (state_q == S_SCAN && rd_vld_s1) prev_end_q <= end_s1;
		if (state_q == S_TAIL && (found_q || take)) status_q <= STAT_DONE;
		if (state_q == S_SCAN_F && rd_vld_s1 && match_s1) status_q <= STAT_DONE;
	end

	logic [31:0] at_w;
	assign at_w       = 32'(at_q);
	assign res.status = status_q;
	assign res.addr   = (status_q == STAT_DONE && kind_q == KIND_ALLOC) ? at_w[15:0] : 16'd0;

endmodule

// ===== sv/contiguous_partition_allocator_unit.sv =====
// Contiguous partition allocator. One request is worked at a time. Its pace is
// set by the segment table, a single memory with one read and one write port,
// which is scanned one entry a cycle and then shifted one entry a cycle to
// insert or remove. A result waits in an output register while the next
// request is taken. A write of reserved_length empties the table back to the
// reserved region at once; the other registers are read while a request is
// worked, so a write to one of them also changes a request in progress.
// depends on cpa_pkg and cpa_engine
module contiguous_partition_allocator_unit #(
	parameter int MAX_SEGMENTS = cpa_pkg::MAX_SEGMENTS_DFLT,
	parameter int ADDRESS_BITS = cpa_pkg::ADDRESS_BITS_DFLT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // job_id[7:0], request_size[23:8]
	input  logic [0:0]  s_tuser,   // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // start_address[15:0]
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import cpa_pkg::*;

	logic [1:0]  fit_q;
	logic [15:0] top_q, rsv_q;
	logic        cfg_wr;
	cfg_t        cfg;
	req_t        req;
	res_t        res;
	logic        res_valid, res_ready;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q <= RESET_FIT_MODE;
			top_q <= RESET_MEMORY_TOP;
			rsv_q <= RESET_RSV_LENGTH;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_FIT_MODE:   fit_q <= cfg_data[1:0];
				REG_MEMORY_TOP: top_q <= cfg_data;
				REG_RSV_LENGTH: rsv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.fit_mode = fit_q;
	assign cfg.mem_top  = top_q;
	assign cfg.rsv_len  = rsv_q;
	assign cfg.clear    = cfg_wr && (cfg_index == REG_RSV_LENGTH);

	assign req.kind   = s_tuser[0];
	assign req.job_id = s_tdata[7:0];
	assign req.size   = s_tdata[23:8];

	cpa_engine #(
		.MAX_SEG (MAX_SEGMENTS),
		.AW      (ADDRESS_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register parts the result beat from the engine
	assign res_ready = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (res_ready) begin
			m_tvalid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata <= res.addr;
			m_tuser <= res.status;
		end
	end

endmodule

// ===== sv/cpa_checker.sv =====
// port-level checks of the partition allocator, bound to the top level
// depends on cpa_pkg and the assertion macro header
`include "contiguous_partition_allocator_unit_defines.svh"

module cpa_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [15:0] cfg_data
);
	import cpa_pkg::*;

	// one request in flight: no second beat right after an accepted one
	`CPA_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// a failed request never reports an address
	`CPA_ASSERT_IMP(a_addr_zero_on_fail, clk, arst_n, m_tvalid && (m_tuser != STAT_DONE), m_tdata == 16'd0)

	// a stalled result beat holds its value
	`CPA_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind contiguous_partition_allocator_unit cpa_port_checks u_cpa_port_checks (.*);

// ===== sim/cpa_checker.sv =====
// watches the request, result and register channels of the partition allocator
// keeps its own segment table, predicts each result and compares; depends on cpa_pkg
module cpa_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import cpa_pkg::*;

	localparam int NSEG = MAX_SEGMENTS_DFLT;

	typedef struct packed {
		status_t     status;
		logic [15:0] addr;
	} alloc_res_t;

	logic [1:0]  fit;
	logic [15:0] mem_top;
	logic [15:0] rsv_len;
	logic [7:0]  seg_owner [NSEG];
	logic [16:0] seg_start [NSEG];
	logic [16:0] seg_len [NSEG];
	int          seg_cnt;
	alloc_res_t  awaited [$];

	task automatic clear_segments();
		seg_owner[0] = 8'd0;
		seg_start[0] = 17'd0;
		seg_len[0] = {1'b0, rsv_len};
		seg_cnt = 1;
	endtask

	function automatic alloc_res_t place_segment(logic [7:0] id, logic [15:0] size);
		alloc_res_t r;
		logic [16:0] top1, seg_end, lim, gap, best_gap, best_at;
		int best_pos;
		bit found, take;
		r.status = STAT_DONE;
		r.addr = 16'd0;
		top1 = {1'b0, mem_top} + 17'd1;
		found = 0;
		best_gap = 0;
		best_at = 0;
		best_pos = 0;
		if (size == 0) begin
			r.status = STAT_NO_FIT;
			return r;
		end
		if (seg_cnt >= NSEG) begin
			r.status = STAT_FULL;
			return r;
		end
		if (seg_cnt == 0 && top1 >= size) found = 1;
		for (int i = 0; i < seg_cnt; i++) begin
			seg_end = seg_start[i] + seg_len[i];
			lim = (i + 1 < seg_cnt) ? seg_start[i + 1] : top1;
			if (seg_end >= lim) continue;
			gap = lim - seg_end;
			if (gap < size) continue;
			if (fit == FIT_BEST) take = !found || gap < best_gap;
			else if (fit == FIT_WORST) take = !found || gap > best_gap;
			else take = !found;
			if (take) begin
				found = 1;
				best_gap = gap;
				best_at = seg_end;
				best_pos = i + 1;
			end
		end
		if (!found) begin
			r.status = STAT_NO_FIT;
			return r;
		end
		for (int k = seg_cnt; k > best_pos; k--) begin
			seg_owner[k] = seg_owner[k - 1];
			seg_start[k] = seg_start[k - 1];
			seg_len[k] = seg_len[k - 1];
		end
		seg_owner[best_pos] = id;
		seg_start[best_pos] = {1'b0, best_at[15:0]};
		seg_len[best_pos] = {1'b0, size};
		seg_cnt++;
		r.addr = best_at[15:0];
		return r;
	endfunction

	function automatic alloc_res_t release_segment(logic [7:0] id);
		alloc_res_t r;
		r.status = STAT_NOT_FOUND;
		r.addr = 16'd0;
		for (int i = 0; i < seg_cnt; i++) begin
			if (seg_owner[i] == id) begin
				for (int k = i; k + 1 < seg_cnt; k++) begin
					seg_owner[k] = seg_owner[k + 1];
					seg_start[k] = seg_start[k + 1];
					seg_len[k] = seg_len[k + 1];
				end
				seg_cnt--;
				r.status = STAT_DONE;
				return r;
			end
		end
		return r;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		fit = RESET_FIT_MODE;
		mem_top = RESET_MEMORY_TOP;
		rsv_len = RESET_RSV_LENGTH;
		clear_segments();
	end

	always @(posedge clk) begin
		alloc_res_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FIT_MODE: fit = cfg_data[1:0];
					REG_MEMORY_TOP: mem_top = cfg_data;
					REG_RSV_LENGTH: begin
						rsv_len = cfg_data;
						clear_segments();
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					$display("%0t: unexpected beat status %0d addr %0d", $time, m_tuser, m_tdata);
					errors++;
				end else begin
					e = awaited.pop_front();
					if (m_tuser !== e.status) begin
						$display("%0t: status expected %0d actual %0d", $time, e.status, m_tuser);
						errors++;
					end
					if (m_tdata !== e.addr) begin
						$display("%0t: addr expected %0d actual %0d", $time, e.addr, m_tdata);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == KIND_ALLOC) awaited.push_back(place_segment(s_tdata[7:0], s_tdata[23:8]));
				else awaited.push_back(release_segment(s_tdata[7:0]));
			end
			pending = awaited.size();
		end
	end
endmodule

// ===== sim/tb.sv =====
// stimulus top for the partition allocator: clock, reset, requests, register writes
// depends on cpa_pkg, the allocator RTL and cpa_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cpa_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [23:0] s_tdata = 0;
	logic [0:0]  s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 0;
	logic [15:0] cfg_data = 0;
	int          errors;
	int          pending;
	int          stall_mode = 0;
	logic [7:0]  live_ids [$];

	always #2 clk = ~clk;

	contiguous_partition_allocator_unit dut (.*);
	cpa_checker chk (.*);

	// receiver stall pattern, changes character now and then
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 1) != 0);
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic send_req(logic kind, logic [7:0] id, logic [15:0] size);
		s_tuser <= kind;
		s_tdata <= {size, id};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		go_idle();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_RSV_LENGTH) live_ids.delete();
	endtask

	task automatic gap_maybe();
		if ($urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
		end
	endtask

	function automatic logic [15:0] pick_size(logic [15:0] top);
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'd0;
			2: return top;
			default: return 16'($urandom_range(1, top / 8 + 1));
		endcase
	endfunction

	task automatic random_phase(int n, logic [15:0] top);
		logic [7:0] id;
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(0, 12)) @(negedge clk);
				burst = $urandom_range(1, 20);
			end
			burst--;
			if (live_ids.size() > 0 && $urandom_range(0, 2) == 0) begin
				id = live_ids[$urandom_range(0, live_ids.size() - 1)];
				send_req(KIND_FREE, id, 16'($urandom));
			end else if ($urandom_range(0, 9) == 0) begin
				send_req(KIND_FREE, 8'($urandom), 16'($urandom));
			end else begin
				id = 8'($urandom_range(0, 255));
				live_ids.push_back(id);
				if (live_ids.size() > 40) void'(live_ids.pop_front());
				send_req(KIND_ALLOC, id, pick_size(top));
			end
		end
	endtask

	initial begin
		logic [15:0] tops [4];
		tops = '{16'd1023, 16'd65535, 16'd0, 16'd300};
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: extremes, both kinds, table full, reserved owner, empty table
		send_req(KIND_ALLOC, 8'd1, 16'd0);
		send_req(KIND_ALLOC, 8'd255, 16'd1);
		send_req(KIND_ALLOC, 8'd2, 16'd65535);
		send_req(KIND_ALLOC, 8'd3, 16'd1014);
		send_req(KIND_FREE, 8'd255, 16'hffff);
		send_req(KIND_FREE, 8'd99, 16'd0);
		for (int i = 0; i < 16; i++) send_req(KIND_ALLOC, 8'(i + 10), 16'd4);
		send_req(KIND_FREE, 8'd0, 16'd0);
		send_req(KIND_FREE, 8'd10, 16'd0);
		send_req(KIND_ALLOC, 8'd0, 16'd2);
		write_reg(REG_RSV_LENGTH, 16'd0);
		send_req(KIND_FREE, 8'd0, 16'd0);
		send_req(KIND_ALLOC, 8'd5, 16'd1024);
		send_req(KIND_ALLOC, 8'd6, 16'd1);
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_FIT_MODE, 16'(ph % 4));
			write_reg(REG_MEMORY_TOP, tops[ph % 4]);
			write_reg(REG_RSV_LENGTH, (ph == 5) ? 16'hffff : 16'($urandom_range(0, 64)));
			random_phase(90, tops[ph % 4]);
		end
		go_idle();
		if (errors == 0) $display("tb: done, clean");
		else $display("tb: done, errors");
		$finish;
	end

	initial begin
		#4ms;
		$display("tb: done, errors");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+sv
sv/cpa_pkg.sv
sv/cpa_engine.sv
sv/contiguous_partition_allocator_unit.sv
sv/cpa_checker.sv
sim/cpa_checker.sv
sim/tb.sv
